[rtl/dbt_pkg.sv]
// Shared types and constants for the DRAM bank timing state machine.
// Used by dbt_cfg, dbt_core and dram_bank_timing_fsm; depends on nothing.
package dbt_pkg;

  localparam int BURST_LEN = 8;
  localparam int ROW_BITS  = 16;
  localparam int BEAT_W    = $clog2(BURST_LEN + 1);

  localparam int MODE_W  = 3;
  localparam int ROW_W   = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 8;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE        = 2'd0,
    ST_ACTIVATING  = 2'd1,
    ST_ACTIVE      = 2'd2,
    ST_PRECHARGING = 2'd3
  } bank_state_t;

  typedef enum logic [2:0] {
    CMD_NOP = 3'd0,
    CMD_ACT = 3'd1,
    CMD_RD  = 3'd2,
    CMD_WR  = 3'd3,
    CMD_PRE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_TRCD = 3'd0,
    CFG_TRP  = 3'd1,
    CFG_TRAS = 3'd2,
    CFG_TRTP = 3'd3,
    CFG_TWR  = 3'd4,
    CFG_TCL  = 3'd5,
    CFG_TWL  = 3'd6,
    CFG_TCCD = 3'd7
  } cfg_idx_t;

  localparam logic [5:0] TRCD_RST = 6'd14;
  localparam logic [5:0] TRP_RST  = 6'd14;
  localparam logic [7:0] TRAS_RST = 8'd33;
  localparam logic [5:0] TRTP_RST = 6'd5;
  localparam logic [5:0] TWR_RST  = 6'd16;
  localparam logic [5:0] TCL_RST  = 6'd14;
  localparam logic [5:0] TWL_RST  = 6'd4;
  localparam logic [3:0] TCCD_RST = 4'd2;

  typedef struct packed {
    logic [5:0] trcd;
    logic [5:0] trp;
    logic [7:0] tras;
    logic [5:0] trtp;
    logic [5:0] twr;
    logic [5:0] tcl;
    logic [5:0] twl;
    logic [3:0] tccd;
  } cfg_t;

  typedef struct packed {
    logic              cmd_error;
    logic              bank_prepared;
    logic              data_busy;
    logic              pre_ready;
    logic              wr_ready;
    logic              rd_ready;
    logic              act_ready;
    logic              open_row_valid;
    logic [ROW_W-1:0]  open_row;
    bank_state_t       bank_state;
  } res_t;

endpackage

[rtl/dbt_cfg.sv]
// Timing register file for the DRAM bank timing state machine.
// Depends on dbt_pkg for the register indexes, reset values and cfg_t.
module dbt_cfg
  import dbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trcd <= TRCD_RST;
      cfg.trp  <= TRP_RST;
      cfg.tras <= TRAS_RST;
      cfg.trtp <= TRTP_RST;
      cfg.twr  <= TWR_RST;
      cfg.tcl  <= TCL_RST;
      cfg.twl  <= TWL_RST;
      cfg.tccd <= TCCD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TRCD: cfg.trcd <= cfg_wdata[5:0];
        CFG_TRP:  cfg.trp  <= cfg_wdata[5:0];
        CFG_TRAS: cfg.tras <= cfg_wdata[7:0];
        CFG_TRTP: cfg.trtp <= cfg_wdata[5:0];
        CFG_TWR:  cfg.twr  <= cfg_wdata[5:0];
        CFG_TCL:  cfg.tcl  <= cfg_wdata[5:0];
        CFG_TWL:  cfg.twl  <= cfg_wdata[5:0];
        CFG_TCCD: cfg.tccd <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/dbt_core.sv]
// Bank state, open row and timing counters, with the per-tick status logic.
// Depends on dbt_pkg; the state advances once for each step strobe.
module dbt_core
  import dbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [MODE_W-1:0] mode,
  input  logic [ROW_W-1:0]  row,
  input  cfg_t              cfg,
  output res_t              res
);

  bank_state_t          phase, phase_next;
  logic [ROW_BITS-1:0]  active_row, active_row_next;
  logic [ROW_BITS-1:0]  pending_row, pending_row_next;
  logic [5:0]           rcd_count, rcd_count_next;
  logic [5:0]           rp_count, rp_count_next;
  logic [7:0]           ras_count, ras_count_next;
  logic [5:0]           rtp_count, rtp_count_next;
  logic [5:0]           wr_count, wr_count_next;
  logic [5:0]           cl_count, cl_count_next;
  logic [5:0]           wl_count, wl_count_next;
  logic [3:0]           ccd_count, ccd_count_next;
  logic                 overlap_flag, overlap_flag_next;
  logic                 prepared_flag, prepared_flag_next;
  logic [BEAT_W-1:0]    beat_count, beat_count_next;

  logic  is_active, act_rdy, col_rdy, pre_rdy;
  logic  rcd_done, rp_done, first_data, busy;
  cmd_t  cmd;

  assign is_active = (phase == ST_ACTIVE);
  assign act_rdy   = (phase == ST_IDLE);
  assign col_rdy   = is_active && (ccd_count == 4'd0 || ccd_count >= cfg.tccd);
  assign pre_rdy   = is_active && (ras_count >= cfg.tras)
                     && (rtp_count == 6'd0 || rtp_count >= cfg.trtp)
                     && (wr_count == 6'd0 || wr_count >= cfg.twr);
  assign rcd_done  = ({1'b0, rcd_count} + 7'd1) >= {1'b0, cfg.trcd};
  assign rp_done   = ({1'b0, rp_count} + 7'd1) >= {1'b0, cfg.trp};

  always_comb begin
    case (mode)
      CMD_ACT: cmd = act_rdy ? CMD_ACT : CMD_NOP;
      CMD_RD:  cmd = col_rdy ? CMD_RD : CMD_NOP;
      CMD_WR:  cmd = col_rdy ? CMD_WR : CMD_NOP;
      CMD_PRE: cmd = pre_rdy ? CMD_PRE : CMD_NOP;
      default: cmd = CMD_NOP;
    endcase
  end

  always_comb begin
    first_data = (cl_count != 6'd0 && cl_count == cfg.tcl)
                 || (wl_count != 6'd0 && wl_count == cfg.twl)
                 || ((cl_count == 6'd1 || wl_count == 6'd1) && overlap_flag);
    if (beat_count > BEAT_W'(1) && beat_count < BEAT_W'(BURST_LEN)) begin
      beat_count_next = beat_count + BEAT_W'(1);
      busy = 1'b1;
    end else if (beat_count == BEAT_W'(BURST_LEN)) begin
      beat_count_next = '0;
      busy = 1'b1;
    end else if (first_data) begin
      beat_count_next = BEAT_W'(2);
      busy = 1'b1;
    end else begin
      beat_count_next = beat_count;
      busy = 1'b0;
    end
  end

  always_comb begin
    res.bank_state     = phase;
    res.open_row       = is_active ? ROW_W'(active_row) : '0;
    res.open_row_valid = is_active;
    res.act_ready      = act_rdy;
    res.rd_ready       = col_rdy;
    res.wr_ready       = col_rdy;
    res.pre_ready      = pre_rdy;
    res.data_busy      = busy;
    res.bank_prepared  = prepared_flag;
    res.cmd_error      = (mode != CMD_NOP) && (cmd == CMD_NOP);
  end

  always_comb begin
    phase_next       = phase;
    pending_row_next = pending_row;
    active_row_next  = active_row;
    case (phase)
      ST_IDLE: begin
        if (cmd == CMD_ACT) begin
          phase_next       = ST_ACTIVATING;
          pending_row_next = ROW_BITS'(row);
        end
      end
      ST_ACTIVATING: begin
        if (rcd_done) begin
          phase_next      = ST_ACTIVE;
          active_row_next = pending_row;
        end
      end
      ST_ACTIVE: begin
        if (cmd == CMD_PRE) phase_next = ST_PRECHARGING;
      end
      ST_PRECHARGING: begin
        if (rp_done) phase_next = ST_IDLE;
      end
      default: phase_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd == CMD_RD && ({1'b0, cl_count} + 7'd1) == {1'b0, cfg.tcl}) begin
      overlap_flag_next = 1'b1;
    end else if (cmd == CMD_WR && ({1'b0, wl_count} + 7'd1) == {1'b0, cfg.twl}) begin
      overlap_flag_next = 1'b1;
    end else begin
      overlap_flag_next = 1'b0;
    end

    if (!prepared_flag && phase == ST_ACTIVATING && rcd_done) begin
      prepared_flag_next = 1'b1;
    end else if (cmd == CMD_RD || cmd == CMD_WR || cmd == CMD_PRE) begin
      prepared_flag_next = 1'b0;
    end else begin
      prepared_flag_next = prepared_flag;
    end

    if (cmd == CMD_ACT) rcd_count_next = 6'd1;
    else if (phase == ST_ACTIVATING) rcd_count_next = rcd_done ? 6'd0 : rcd_count + 6'd1;
    else rcd_count_next = 6'd0;

    if (cmd == CMD_PRE) rp_count_next = 6'd1;
    else if (cmd == CMD_ACT) rp_count_next = 6'd0;
    else if (rp_count >= 6'd1 && rp_count < cfg.trp) rp_count_next = rp_count + 6'd1;
    else rp_count_next = rp_count;

    if (cmd == CMD_ACT) ras_count_next = 8'd1;
    else if (cmd == CMD_PRE) ras_count_next = 8'd0;
    else if (ras_count >= 8'd1 && ras_count != 8'hFF) ras_count_next = ras_count + 8'd1;
    else ras_count_next = ras_count;

    if (cmd == CMD_RD) rtp_count_next = 6'd1;
    else if (cmd == CMD_PRE) rtp_count_next = 6'd0;
    else if (rtp_count >= 6'd1 && rtp_count != 6'h3F) rtp_count_next = rtp_count + 6'd1;
    else rtp_count_next = rtp_count;

    if (cmd == CMD_WR) wr_count_next = 6'd1;
    else if (cmd == CMD_PRE) wr_count_next = 6'd0;
    else if (wr_count >= 6'd1 && wr_count != 6'h3F) wr_count_next = wr_count + 6'd1;
    else wr_count_next = wr_count;

    if (cmd == CMD_RD) cl_count_next = 6'd1;
    else if (cl_count >= cfg.tcl) cl_count_next = 6'd0;
    else if (cl_count >= 6'd1) cl_count_next = cl_count + 6'd1;
    else cl_count_next = cl_count;

    if (cmd == CMD_WR) wl_count_next = 6'd1;
    else if (wl_count >= cfg.twl) wl_count_next = 6'd0;
    else if (wl_count >= 6'd1) wl_count_next = wl_count + 6'd1;
    else wl_count_next = wl_count;

    if (cmd == CMD_RD || cmd == CMD_WR) ccd_count_next = 4'd1;
    else if (ccd_count >= cfg.tccd) ccd_count_next = 4'd0;
    else if (ccd_count >= 4'd1) ccd_count_next = ccd_count + 4'd1;
    else ccd_count_next = ccd_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ST_IDLE;
      active_row    <= '0;
      pending_row   <= '0;
      rcd_count     <= '0;
      rp_count      <= TRP_RST;
      ras_count     <= '0;
      rtp_count     <= '0;
      wr_count      <= '0;
      cl_count      <= '0;
      wl_count      <= '0;
      ccd_count     <= '0;
      overlap_flag  <= 1'b0;
      prepared_flag <= 1'b0;
      beat_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      active_row    <= active_row_next;
      pending_row   <= pending_row_next;
      rcd_count     <= rcd_count_next;
      rp_count      <= rp_count_next;
      ras_count     <= ras_count_next;
      rtp_count     <= rtp_count_next;
      wr_count      <= wr_count_next;
      cl_count      <= cl_count_next;
      wl_count      <= wl_count_next;
      ccd_count     <= ccd_count_next;
      overlap_flag  <= overlap_flag_next;
      prepared_flag <= prepared_flag_next;
      beat_count    <= beat_count_next;
    end
  end

endmodule

[rtl/dram_bank_timing_fsm.sv]
// Top level of the DRAM bank timing state machine: input register, core, result register.
// Depends on dbt_pkg, dbt_cfg and dbt_core.
//
//   channel   direction  word
//   s_axis    in         one command tick: mode, row
//   m_axis    out        bank status sampled before that tick's command
//   cfg       in         timing register write, index 0 to 7
//
// One word is accepted per cycle while the output does not stall; results are registered.
// The bank state and all counters advance when a word leaves the input register.
// Reset clears the bank to idle, the timing registers to their defaults and both stages.
// A stalled output holds its word; the input register keeps taking words while it can.
module dram_bank_timing_fsm
  import dbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // mode[2:0], row[18:3], zero fill
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // bank_state[1:0], open_row[17:2],
                                            // open_row_valid, act_ready, rd_ready,
                                            // wr_ready, pre_ready, data_busy,
                                            // bank_prepared, cmd_error, zero fill
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t              cfg;
  res_t              res;
  res_t              out_res;
  logic              in_valid;
  logic [MODE_W-1:0] in_mode;
  logic [ROW_W-1:0]  in_row;
  logic              advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= s_axis_tdata[2:0];
      in_row  <= s_axis_tdata[18:3];
    end
  end

  dbt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .mode (in_mode),
    .row  (in_row),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.cmd_error, out_res.bank_prepared, out_res.data_busy,
                         out_res.pre_ready, out_res.wr_ready, out_res.rd_ready,
                         out_res.act_ready, out_res.open_row_valid, out_res.open_row,
                         out_res.bank_state};

`ifndef SYNTHESIS
  a_row_valid_tracks_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.open_row_valid == (out_res.bank_state == ST_ACTIVE)))
    else $error("open_row_valid disagrees with bank_state");

  a_prepared_only_active: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.bank_prepared) |-> (out_res.bank_state == ST_ACTIVE))
    else $error("bank_prepared reported outside the active state");

  a_col_ready_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.rd_ready == out_res.wr_ready))
    else $error("read and write readiness differ");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline could move");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for dram_bank_timing_fsm: drives command ticks, predicts the bank
// status of every tick with an in-bench bank timing model and compares each result word.
// Depends on rtl/dbt_pkg.sv and the dram_bank_timing_fsm RTL.
`timescale 1ns / 1ps

module tb;
  import dbt_pkg::*;

  typedef struct {
    bank_state_t       phase;
    logic [ROW_W-1:0]  row_open;
    logic [ROW_W-1:0]  row_pend;
    logic [5:0]        rcd;
    logic [5:0]        rp;
    logic [7:0]        ras;
    logic [5:0]        rtp;
    logic [5:0]        wrc;
    logic [5:0]        cl;
    logic [5:0]        wl;
    logic [3:0]        ccd;
    logic              overlap;
    logic              prepared;
    logic [BEAT_W-1:0] beat;
  } bank_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [MODE_W-1:0] mode;
  } tick_t;

  localparam cfg_t DEFAULT_TIMING = '{trcd: TRCD_RST, trp: TRP_RST, tras: TRAS_RST,
                                      trtp: TRTP_RST, twr: TWR_RST, tcl: TCL_RST,
                                      twl: TWL_RST, tccd: TCCD_RST};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  tick_t  tick_q[$];
  res_t   status_q[$];
  bank_t  chk_bank;
  bank_t  gen_bank;
  cfg_t   tim;
  cfg_t   plan_cfg;
  tick_t  cur;
  res_t   want_st;
  res_t   got_st;
  int     fails = 0;
  int     gap_left = 0;
  int     stall_left;
  bit     calm = 1'b0;
  bit     long_hold = 1'b0;
  bit     hold_taken;

  dram_bank_timing_fsm uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic bank_t bank_at_reset();
    bank_t b;
    b.phase = ST_IDLE;
    b.row_open = '0;
    b.row_pend = '0;
    b.rcd = '0;
    b.rp = TRP_RST;
    b.ras = '0;
    b.rtp = '0;
    b.wrc = '0;
    b.cl = '0;
    b.wl = '0;
    b.ccd = '0;
    b.overlap = 1'b0;
    b.prepared = 1'b0;
    b.beat = '0;
    return b;
  endfunction

  // Returns the status seen before the command, then applies the command to the bank.
  function automatic res_t advance_bank(inout bank_t b, input cfg_t c,
                                        input logic [MODE_W-1:0] mode,
                                        input logic [ROW_W-1:0] row);
    res_t        r;
    bank_state_t st;
    logic        act_rdy, col_rdy, pre_rdy, rcd_done, rp_done, first, busy;
    cmd_t        cmd;
    st = b.phase;
    act_rdy = (st == ST_IDLE);
    col_rdy = (st == ST_ACTIVE) && (b.ccd == 0 || b.ccd >= c.tccd);
    pre_rdy = (st == ST_ACTIVE) && b.ras >= c.tras && (b.rtp == 0 || b.rtp >= c.trtp)
              && (b.wrc == 0 || b.wrc >= c.twr);
    rcd_done = (int'(b.rcd) + 1 >= int'(c.trcd));
    rp_done = (int'(b.rp) + 1 >= int'(c.trp));
    cmd = CMD_NOP;
    case (mode)
      CMD_ACT: if (act_rdy) cmd = CMD_ACT;
      CMD_RD:  if (col_rdy) cmd = CMD_RD;
      CMD_WR:  if (col_rdy) cmd = CMD_WR;
      CMD_PRE: if (pre_rdy) cmd = CMD_PRE;
      default: ;
    endcase
    r.bank_state = st;
    r.open_row = (st == ST_ACTIVE) ? b.row_open : '0;
    r.open_row_valid = (st == ST_ACTIVE);
    r.act_ready = act_rdy;
    r.rd_ready = col_rdy;
    r.wr_ready = col_rdy;
    r.pre_ready = pre_rdy;
    r.bank_prepared = b.prepared;
    r.cmd_error = (mode != CMD_NOP) && (cmd == CMD_NOP);

    first = (b.cl != 0 && b.cl == c.tcl) || (b.wl != 0 && b.wl == c.twl)
            || ((b.cl == 1 || b.wl == 1) && b.overlap);
    busy = 1'b1;
    if (b.beat > 1 && b.beat < BURST_LEN) b.beat = b.beat + 1'b1;
    else if (b.beat == BURST_LEN) b.beat = '0;
    else if (first) b.beat = BEAT_W'(2);
    else busy = 1'b0;
    r.data_busy = busy;

    case (st)
      ST_IDLE: if (cmd == CMD_ACT) begin
        b.phase = ST_ACTIVATING;
        b.row_pend = row;
      end
      ST_ACTIVATING: if (rcd_done) begin
        b.phase = ST_ACTIVE;
        b.row_open = b.row_pend;
      end
      ST_ACTIVE: if (cmd == CMD_PRE) b.phase = ST_PRECHARGING;
      default: if (rp_done) b.phase = ST_IDLE;
    endcase

    b.overlap = (cmd == CMD_RD && int'(b.cl) + 1 == int'(c.tcl))
                || (cmd == CMD_WR && int'(b.wl) + 1 == int'(c.twl));

    if (!b.prepared && st == ST_ACTIVATING && rcd_done) b.prepared = 1'b1;
    else if (cmd == CMD_RD || cmd == CMD_WR || cmd == CMD_PRE) b.prepared = 1'b0;

    if (cmd == CMD_ACT) b.rcd = 6'd1;
    else if (st == ST_ACTIVATING) b.rcd = rcd_done ? 6'd0 : b.rcd + 1'b1;
    else b.rcd = '0;

    if (cmd == CMD_PRE) b.rp = 6'd1;
    else if (cmd == CMD_ACT) b.rp = '0;
    else if (b.rp >= 1 && b.rp < c.trp) b.rp = b.rp + 1'b1;

    if (cmd == CMD_ACT) b.ras = 8'd1;
    else if (cmd == CMD_PRE) b.ras = '0;
    else if (b.ras >= 1 && b.ras < 255) b.ras = b.ras + 1'b1;

    if (cmd == CMD_RD) b.rtp = 6'd1;
    else if (cmd == CMD_PRE) b.rtp = '0;
    else if (b.rtp >= 1 && b.rtp < 63) b.rtp = b.rtp + 1'b1;

    if (cmd == CMD_WR) b.wrc = 6'd1;
    else if (cmd == CMD_PRE) b.wrc = '0;
    else if (b.wrc >= 1 && b.wrc < 63) b.wrc = b.wrc + 1'b1;

    if (cmd == CMD_RD) b.cl = 6'd1;
    else if (b.cl >= c.tcl) b.cl = '0;
    else if (b.cl >= 1) b.cl = b.cl + 1'b1;

    if (cmd == CMD_WR) b.wl = 6'd1;
    else if (b.wl >= c.twl) b.wl = '0;
    else if (b.wl >= 1) b.wl = b.wl + 1'b1;

    if (cmd == CMD_RD || cmd == CMD_WR) b.ccd = 4'd1;
    else if (b.ccd >= c.tccd) b.ccd = '0;
    else if (b.ccd >= 1) b.ccd = b.ccd + 1'b1;

    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cfg_t pick_timing();
    cfg_t c;
    c.trcd = 6'($urandom_range(1, 6));
    c.trp = 6'($urandom_range(1, 6));
    c.tras = 8'($urandom_range(1, 20));
    c.trtp = 6'($urandom_range(1, 8));
    c.twr = 6'($urandom_range(1, 10));
    c.tcl = 6'($urandom_range(1, 10));
    c.twl = 6'($urandom_range(1, 8));
    c.tccd = 4'($urandom_range(1, 6));
    return c;
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fails++;
    end
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_timing(input cfg_t c);
    write_reg(CFG_TRCD, 8'(c.trcd));
    write_reg(CFG_TRP, 8'(c.trp));
    write_reg(CFG_TRAS, c.tras);
    write_reg(CFG_TRTP, 8'(c.trtp));
    write_reg(CFG_TWR, 8'(c.twr));
    write_reg(CFG_TCL, 8'(c.tcl));
    write_reg(CFG_TWL, 8'(c.twl));
    write_reg(CFG_TCCD, 8'(c.tccd));
    @(posedge clk);
    cfg_we <= 1'b0;
    tim = c;
    plan_cfg = c;
  endtask

  task automatic push_tick(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row);
    tick_q.push_back(tick_t'{row, mode});
    void'(advance_bank(gen_bank, plan_cfg, mode, row));
  endtask

  // Mostly legal command streams so the bank cycles through all its states, plus noise.
  task automatic gen_ticks(input int n);
    bank_t             peek;
    res_t              rdy;
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row;
    int                pick;
    repeat (n) begin
      peek = gen_bank;
      rdy = advance_bank(peek, plan_cfg, CMD_NOP, '0);
      mode = CMD_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        mode = MODE_W'($urandom_range(0, 7));
      end else if (pick < 75) begin
        if (rdy.act_ready) mode = CMD_ACT;
        else if (rdy.pre_ready && $urandom_range(0, 2) == 0) mode = CMD_PRE;
        else if (rdy.rd_ready && $urandom_range(0, 1) == 0)
          mode = $urandom_range(0, 1) ? CMD_RD : CMD_WR;
      end
      case ($urandom_range(0, 7))
        0: row = '0;
        1: row = '1;
        default: row = ROW_W'($urandom);
      endcase
      push_tick(mode, row);
    end
  endtask

  // Waits past each edge so that the driver's and the monitor's updates have settled.
  task automatic drain();
    while (tick_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int n, input bit quiet, input bit hold);
    load_timing(c);
    calm = quiet;
    long_hold = hold;
    gen_ticks(n);
    drain();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(advance_bank(chk_bank, tim, cur.mode, cur.row));
        gap_left = pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || tick_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur = tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_W'({cur.row, cur.mode});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else if (long_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      stall_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        $error("result word arrived with no expected status pending");
        fails++;
      end else begin
        want_st = status_q.pop_front();
        got_st = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        check_field("bank_state", want_st.bank_state, got_st.bank_state);
        check_field("open_row", want_st.open_row, got_st.open_row);
        check_field("open_row_valid", want_st.open_row_valid, got_st.open_row_valid);
        check_field("act_ready", want_st.act_ready, got_st.act_ready);
        check_field("rd_ready", want_st.rd_ready, got_st.rd_ready);
        check_field("wr_ready", want_st.wr_ready, got_st.wr_ready);
        check_field("pre_ready", want_st.pre_ready, got_st.pre_ready);
        check_field("data_busy", want_st.data_busy, got_st.data_busy);
        check_field("bank_prepared", want_st.bank_prepared, got_st.bank_prepared);
        check_field("cmd_error", want_st.cmd_error, got_st.cmd_error);
      end
    end
  end

  initial begin
    cfg_t fastest, slowest, degenerate;
    tim = DEFAULT_TIMING;
    plan_cfg = DEFAULT_TIMING;
    chk_bank = bank_at_reset();
    gen_bank = bank_at_reset();
    fastest = '{trcd: 6'd2, trp: 6'd2, tras: 8'd1, trtp: 6'd1, twr: 6'd1, tcl: 6'd2,
                twl: 6'd2, tccd: 4'd1};
    slowest = '{trcd: 6'd63, trp: 6'd63, tras: 8'd255, trtp: 6'd63, twr: 6'd63,
                tcl: 6'd63, twl: 6'd63, tccd: 4'd15};
    degenerate = '{trcd: 6'd0, trp: 6'd1, tras: 8'd0, trtp: 6'd0, twr: 6'd0, tcl: 6'd0,
                   twl: 6'd0, tccd: 4'd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: illegal commands in idle, unknown modes, a full activate,
    // back-to-back column commands, precharge and an activate refused while precharging.
    load_timing(fastest);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_RD, '0);
    push_tick(CMD_WR, '0);
    push_tick(CMD_PRE, '0);
    push_tick(3'd5, 16'h5555);
    push_tick(3'd6, 16'hAAAA);
    push_tick(3'd7, '1);
    push_tick(CMD_ACT, '1);
    push_tick(CMD_ACT, '0);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_RD, '0);
    push_tick(CMD_RD, '0);
    push_tick(CMD_WR, '0);
    push_tick(CMD_WR, '0);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_ACT, 16'h1234);
    push_tick(CMD_PRE, '0);
    push_tick(CMD_ACT, '0);
    push_tick(CMD_RD, '0);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_NOP, '0);
    push_tick(CMD_ACT, '0);
    push_tick(CMD_NOP, '0);
    gen_ticks(190);
    drain();

    run_phase(DEFAULT_TIMING, 215, 1'b0, 1'b0);
    run_phase(slowest, 215, 1'b0, 1'b0);
    run_phase(degenerate, 215, 1'b0, 1'b0);
    run_phase(pick_timing(), 215, 1'b1, 1'b0);
    run_phase(pick_timing(), 215, 1'b0, 1'b1);
    run_phase(pick_timing(), 215, 1'b0, 1'b0);
    run_phase(pick_timing(), 215, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/dbt_pkg.sv
rtl/dbt_cfg.sv
rtl/dbt_core.sv
rtl/dram_bank_timing_fsm.sv
verif/tb.sv
